### hw/rtl/set_assoc_cache_tree_plru_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the set-associative tag store
// Implication checks sampled on the rising clock edge, off while in reset.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_TREE_PLRU_DEFINES_SVH
`define SET_ASSOC_CACHE_TREE_PLRU_DEFINES_SVH

`ifndef ASSERT_OFF
`define SACP_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
`define SACP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SACP_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define SACP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

### hw/rtl/sacp_pkg.sv
// ----------------------------------------------------------------------------
// sacp_pkg
// Field widths and access codes shared by the tag store.
// ----------------------------------------------------------------------------
package sacp_pkg;

  localparam int OP_W      = 1;
  localparam int SET_IDX_W = 6;
  localparam int TAG_IN_W  = 20;
  localparam int WAY_OUT_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

endpackage

### hw/rtl/sacp_ram.sv
// ----------------------------------------------------------------------------
// sacp_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sacp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/set_assoc_cache_tree_plru.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tree_plru
// Tag store of a write-back set-associative cache with tree pseudo-LRU
// replacement. One RAM row per set holds tags, valid, dirty and tree bits.
//
//   channel   ports                                     handshake
//   request   in_op, in_set_index, in_tag               start / busy
//   result    out_hit, out_way, out_victim_valid,       out_valid, 1 cycle
//             out_victim_dirty
//
// A request is accepted in idle, when the set row is read from the single tag RAM;
// in the lookup state it is compared, updated and written back, with busy high.
// The result strobes on out_valid, registered at the same edge as the write-back.
// After reset a clearing pass writes every row, with busy high.
// The receiver cannot stall the result.
// ----------------------------------------------------------------------------
`include "set_assoc_cache_tree_plru_defines.svh"

module set_assoc_cache_tree_plru
  import sacp_pkg::*;
#(
  parameter int WAYS     = 4,
  parameter int SETS     = 64,
  parameter int TAG_BITS = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [OP_W-1:0]      in_op,
  input  logic [SET_IDX_W-1:0] in_set_index,
  input  logic [TAG_IN_W-1:0]  in_tag,
  output logic                 out_valid,
  output logic                 out_hit,
  output logic [WAY_OUT_W-1:0] out_way,
  output logic                 out_victim_valid,
  output logic                 out_victim_dirty
);

  localparam int WAY_W   = $clog2(WAYS);
  localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int TAG_W   = (TAG_BITS < TAG_IN_W) ? TAG_BITS : TAG_IN_W;
  localparam int NODES   = WAYS - 1;
  localparam int IDX_CNT = 1 << SET_IDX_W;

  typedef struct packed {
    logic [WAYS-1:0][TAG_W-1:0] tags;
    logic [WAYS-1:0]            valid;
    logic [WAYS-1:0]            dirty;
    logic [NODES-1:0]           plru;
  } row_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  state_t           state_r, state_nxt;
  logic [SET_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [SET_W-1:0] set_r, set_nxt;
  logic [TAG_W-1:0] tag_r, tag_nxt;
  logic             wr_r, wr_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_hit_r, out_hit_nxt;
  logic [WAY_W-1:0] out_way_r, out_way_nxt;
  logic             out_vv_r, out_vv_nxt;
  logic             out_vd_r, out_vd_nxt;

  logic [SET_W-1:0] set_mod_tbl [IDX_CNT];
  logic [SET_W-1:0] set_in;
  row_t             row_rd, row_upd, ram_wdata;
  logic [SET_W-1:0] ram_waddr;
  logic             ram_we;
  logic             hit;
  logic [WAY_W-1:0] hit_way, vic_way, acc_way;
  logic             vic_match;

  for (genvar g = 0; g < IDX_CNT; g++) begin : g_set_mod
    assign set_mod_tbl[g] = SET_W'(g % SETS);
  end

  assign set_in = set_mod_tbl[in_set_index];

  sacp_ram #(
    .WIDTH ($bits(row_t)),
    .DEPTH (SETS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (set_in),
    .rdata (row_rd)
  );

  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row_rd.valid[w] && (row_rd.tags[w] == tag_r)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  always_comb begin
    vic_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      vic_match = 1'b1;
      for (int l = 0; l < WAY_W; l++) begin
        if (row_rd.plru[(1 << l) - 1 + (w >> (WAY_W - l))] !=
            1'((w >> (WAY_W - 1 - l)) & 1)) begin
          vic_match = 1'b0;
        end
      end
      if (vic_match) begin
        vic_way = WAY_W'(w);
      end
    end
  end

  assign acc_way = hit ? hit_way : vic_way;

  always_comb begin
    row_upd = row_rd;
    if (hit) begin
      row_upd.dirty[hit_way] = row_rd.dirty[hit_way] | wr_r;
    end else begin
      row_upd.tags[vic_way]  = tag_r;
      row_upd.valid[vic_way] = 1'b1;
      row_upd.dirty[vic_way] = wr_r;
    end
    for (int l = 0; l < WAY_W; l++) begin
      for (int p = 0; p < (1 << l); p++) begin
        if ((acc_way >> (WAY_W - l)) == WAY_W'(p)) begin
          row_upd.plru[(1 << l) - 1 + p] = ~acc_way[WAY_W - 1 - l];
        end
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = set_r;
    ram_wdata = row_upd;
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
      end
      ST_LOOKUP: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    set_nxt       = set_r;
    tag_nxt       = tag_r;
    wr_nxt        = wr_r;
    out_valid_nxt = 1'b0;
    out_hit_nxt   = out_hit_r;
    out_way_nxt   = out_way_r;
    out_vv_nxt    = out_vv_r;
    out_vd_nxt    = out_vd_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == SET_W'(SETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          set_nxt   = set_in;
          tag_nxt   = in_tag[TAG_W-1:0];
          wr_nxt    = (op_t'(in_op) == OP_WRITE);
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        out_valid_nxt = 1'b1;
        out_hit_nxt   = hit;
        out_way_nxt   = acc_way;
        out_vv_nxt    = !hit && row_rd.valid[vic_way];
        out_vd_nxt    = !hit && row_rd.valid[vic_way] && row_rd.dirty[vic_way];
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    set_r     <= set_nxt;
    tag_r     <= tag_nxt;
    wr_r      <= wr_nxt;
    out_hit_r <= out_hit_nxt;
    out_way_r <= out_way_nxt;
    out_vv_r  <= out_vv_nxt;
    out_vd_r  <= out_vd_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_way          = WAY_OUT_W'(out_way_r);
  assign out_victim_valid = out_vv_r;
  assign out_victim_dirty = out_vd_r;

  `SACP_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !out_valid,
    "request accepted but block not busy next cycle")
  `SACP_ASSERT_SAME(a_result_after_lookup, clk, rst_n, out_valid,
    $past(state_r == ST_LOOKUP), "result strobe without a preceding lookup")
  `SACP_ASSERT_SAME(a_hit_no_victim, clk, rst_n, out_valid && out_hit,
    !out_victim_valid && !out_victim_dirty, "victim reported on a hit")
  `SACP_ASSERT_SAME(a_dirty_needs_valid, clk, rst_n, out_valid && out_victim_dirty,
    out_victim_valid, "dirty victim reported without valid victim")

endmodule
